// ===== rtl/ftbi_pkg.sv =====
`default_nettype none

package ftbi_pkg;

  // Table geometry and default parameter values.
  localparam int RowCount    = 16;
  localparam int ColumnCount = 7;

  // Field widths of the two channels.
  localparam int RigWidth  = 12;
  localparam int PotWidth  = 11;
  localparam int FluxWidth = 15;

  // Clamp bounds: rigidity in 1/256 GV, potential in whole MV.
  localparam logic [RigWidth-1:0] RigMin = 12'd128;
  localparam logic [RigWidth-1:0] RigMax = 12'd3814;
  localparam logic [PotWidth-1:0] PotMin = 11'd500;
  localparam logic [PotWidth-1:0] PotMax = 11'd1100;

  // One potential column spans this many MV.
  localparam logic [6:0] PotStep = 7'd100;

  // floor(d / 100) == (d * 41) >> 12 for every d up to 600.
  localparam logic [15:0] ColRecip = 16'd41;

  // Half of the 256 * 100 scale, for rounding half up.
  localparam logic [29:0] RoundHalf = 30'd12800;

  // floor(v / 100) == (v * 5368710) >> 29 for every v below 6.1 million.
  localparam logic [22:0] Recip100  = 23'd5368710;
  localparam int          Recip100Shift = 29;

  // Index and fraction of one item after clamping.
  typedef struct packed {
    logic [3:0] row;   // lower row of the pair
    logic [8:0] fr;    // row fraction in 1/256, up to one
    logic [9:0] pd;    // potential above the lowest column, in MV
    logic [2:0] pq;    // potential column before the top clamp
  } ftbi_index_t;

  // Integrated flux, unsigned Q7.8, rows by rigidity and columns by potential.
  localparam logic [FluxWidth-1:0] FluxRom [16][7] = '{
    '{15'd31293, 15'd22867, 15'd17286, 15'd13433, 15'd10679, 15'd8654, 15'd7128},
    '{15'd17346, 15'd13727, 15'd11074, 15'd9080,  15'd7550,  15'd6355, 15'd5406},
    '{15'd7075,  15'd6057,  15'd5232,  15'd4554,  15'd3993,  15'd3522, 15'd3125},
    '{15'd3692,  15'd3286,  15'd2939,  15'd2641,  15'd2384,  15'd2160, 15'd1964},
    '{15'd2223,  15'd2024,  15'd1849,  15'd1695,  15'd1559,  15'd1437, 15'd1328},
    '{15'd1466,  15'd1356,  15'd1257,  15'd1168,  15'd1088,  15'd1015, 15'd948},
    '{15'd1031,  15'd964,   15'd903,   15'd847,   15'd796,   15'd750,  15'd707},
    '{15'd760,   15'd716,   15'd676,   15'd639,   15'd605,   15'd574,  15'd544},
    '{15'd580,   15'd551,   15'd523,   15'd497,   15'd474,   15'd451,  15'd431},
    '{15'd456,   15'd435,   15'd415,   15'd397,   15'd379,   15'd363,  15'd348},
    '{15'd366,   15'd351,   15'd336,   15'd323,   15'd310,   15'd298,  15'd286},
    '{15'd300,   15'd289,   15'd278,   15'd267,   15'd257,   15'd248,  15'd239},
    '{15'd250,   15'd241,   15'd232,   15'd224,   15'd217,   15'd209,  15'd202},
    '{15'd211,   15'd204,   15'd197,   15'd191,   15'd185,   15'd179,  15'd173},
    '{15'd180,   15'd174,   15'd169,   15'd164,   15'd159,   15'd154,  15'd150},
    '{15'd155,   15'd151,   15'd146,   15'd142,   15'd138,   15'd134,  15'd131}
  };

  // Table read; a column past the table reads as zero.
  function automatic logic [FluxWidth-1:0] flux_at(input logic [3:0] row,
                                                   input logic [2:0] col);
    logic [FluxWidth-1:0] value;
    value = '0;
    if (col < 3'd7) begin
      value = FluxRom[row][col];
    end
    return value;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ftbi_in_if.sv =====
`default_nettype none

interface ftbi_in_if;
  import ftbi_pkg::*;

  logic                valid;
  logic                ready;
  logic [RigWidth-1:0] cutoff_rigidity;
  logic [PotWidth-1:0] solar_potential;

  modport source (output valid, output cutoff_rigidity, output solar_potential,
                  input ready);
  modport sink (input valid, input cutoff_rigidity, input solar_potential,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/ftbi_out_if.sv =====
`default_nettype none

interface ftbi_out_if;
  import ftbi_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [FluxWidth-1:0] vertical_flux;

  modport source (output valid, output vertical_flux, input ready);
  modport sink (input valid, input vertical_flux, output ready);
endinterface

`default_nettype wire

// ===== rtl/flux_table_bilinear_interp.sv =====
`default_nettype none

// Bilinear lookup of energy-integrated vertical flux.
// An item on item_in carries a cutoff rigidity (unsigned Q4.8 GV) and a solar
// modulation potential (whole MV). Both are saturated to 0.5..14.9 GV and
// 500..1100 MV, and the flux is interpolated between the four surrounding
// entries of a constant 16 x 7 table. The rounded unsigned Q7.8 result leaves on
// flux_out, one result beat for each input beat, in order.
// Both channels use a valid/ready handshake; a beat moves at a rising edge
// with both high.
// A beat taken from item_in passes through seven register stages (clamp and
// index, table read, row blend, column blend, rounding, scaling multiply,
// output) and is presented on flux_out from the output register. Each stage
// takes a new beat every cycle while flux_out is ready, so the throughput is one beat a cycle.
// When flux_out is stalled the stages still fill their empty slots, and
// item_in drops ready only once every stage holds a beat; nothing is lost
// or repeated. Reset empties the pipeline; there is no other state.
module flux_table_bilinear_interp #(
  parameter int ROW_COUNT    = ftbi_pkg::RowCount,
  parameter int COLUMN_COUNT = ftbi_pkg::ColumnCount
) (
  input wire logic   clk,
  input wire logic   rst,
  ftbi_in_if.sink    item_in,
  ftbi_out_if.source flux_out
);
  import ftbi_pkg::*;

  localparam int         Stages = 7;
  localparam logic [2:0] TopCol = 3'(COLUMN_COUNT - 2);

  logic [Stages-1:0] vld;
  logic [Stages-1:0] en;

  ftbi_index_t          front_idx;
  ftbi_index_t          s1_idx;
  logic [9:0]           col_x100;
  logic [2:0]           col;
  logic [6:0]           fc;
  logic [8:0]           s2_fr;
  logic [6:0]           s2_fc;
  logic [FluxWidth-1:0] a00;
  logic [FluxWidth-1:0] a10;
  logic [FluxWidth-1:0] a01;
  logic [FluxWidth-1:0] a11;
  logic [8:0]           frw;
  logic [22:0]          t0;
  logic [22:0]          t1;
  logic [6:0]           s3_fc;
  logic [6:0]           s3_fcw;
  logic [29:0]          sum;
  logic [29:0]          sum_rnd;
  logic [21:0]          scaled;
  logic [44:0]          prod;
  logic [FluxWidth-1:0] flux;

  ftbi_front #(
    .ROW_COUNT(ROW_COUNT)
  ) u_front (
    .cutoff_rigidity(item_in.cutoff_rigidity),
    .solar_potential(item_in.solar_potential),
    .idx            (front_idx)
  );

  // A stage takes a new beat when it is empty or its own beat moves on.
  always_comb begin
    en[Stages-1] = !vld[Stages-1] || flux_out.ready;
    for (int i = Stages - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  assign item_in.ready = en[0];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) begin
        vld[0] <= item_in.valid;
      end
      for (int i = 1; i < Stages; i++) begin
        if (en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Column remainder and top clamp: at the highest potential the last column
  // pair is used with fraction one.
  always_comb begin
    col_x100 = 10'(s1_idx.pq) * 10'(PotStep);
    col      = s1_idx.pq;
    fc       = 7'(s1_idx.pd - col_x100);
    if (s1_idx.pq > TopCol) begin
      col = TopCol;
      fc  = PotStep;
    end
  end

  // Complementary row weight, shared by both row blends.
  assign frw = 9'd256 - s2_fr;

  // Rounding is half up on the 256 * 100 scale; the shift drops the 256.
  assign sum_rnd = sum + RoundHalf;

  // Payload stages.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_idx <= front_idx;
    end
    if (en[1]) begin
      s2_fr <= s1_idx.fr;
      s2_fc <= fc;
      a00   <= flux_at(s1_idx.row, col);
      a10   <= flux_at(s1_idx.row + 4'd1, col);
      a01   <= flux_at(s1_idx.row, col + 3'd1);
      a11   <= flux_at(s1_idx.row + 4'd1, col + 3'd1);
    end
    if (en[2]) begin
      t0     <= 23'(a00) * 23'(frw) + 23'(a10) * 23'(s2_fr);
      t1     <= 23'(a01) * 23'(frw) + 23'(a11) * 23'(s2_fr);
      s3_fc  <= s2_fc;
      s3_fcw <= PotStep - s2_fc;
    end
    if (en[3]) begin
      sum <= 30'(t0) * 30'(s3_fcw) + 30'(t1) * 30'(s3_fc);
    end
    if (en[4]) begin
      scaled <= sum_rnd[29:8];
    end
    if (en[5]) begin
      prod <= 45'(scaled) * 45'(Recip100);
    end
    if (en[6]) begin
      flux <= prod[Recip100Shift +: FluxWidth];
    end
  end

  assign flux_out.valid         = vld[Stages-1];
  assign flux_out.vertical_flux = flux;

endmodule

`default_nettype wire

// ===== rtl/ftbi_front.sv =====
`default_nettype none

module ftbi_front #(
  parameter int ROW_COUNT = ftbi_pkg::RowCount
) (
  input  wire logic [ftbi_pkg::RigWidth-1:0] cutoff_rigidity,
  input  wire logic [ftbi_pkg::PotWidth-1:0] solar_potential,
  output ftbi_pkg::ftbi_index_t              idx
);
  import ftbi_pkg::*;

  localparam logic [3:0] TopRow = 4'(ROW_COUNT - 2);

  logic [RigWidth-1:0] rig;
  logic [PotWidth-1:0] pot;
  logic [9:0]          pot_off;
  logic [15:0]         col_prod;

  // Saturate both inputs to the span of the table.
  always_comb begin
    rig = cutoff_rigidity;
    if (rig < RigMin) begin
      rig = RigMin;
    end else if (rig > RigMax) begin
      rig = RigMax;
    end
    pot = solar_potential;
    if (pot < PotMin) begin
      pot = PotMin;
    end else if (pot > PotMax) begin
      pot = PotMax;
    end
  end

  // Potential column by a reciprocal multiply; the remainder follows later.
  assign pot_off  = 10'(pot - PotMin);
  assign col_prod = 16'(pot_off) * ColRecip;

  // Rigidity row and fraction. Below 1 GV the first row spans half a GV,
  // so the fraction there is twice the distance above 0.5 GV.
  always_comb begin
    idx.pd = pot_off;
    idx.pq = col_prod[14:12];
    if (rig[11:8] != 4'd0) begin
      idx.row = rig[11:8];
      idx.fr  = {1'b0, rig[7:0]};
    end else begin
      idx.row = 4'd0;
      idx.fr  = {1'b0, rig[6:0], 1'b0};
    end
    // A reduced table stops at its last row pair with fraction one.
    if (idx.row > TopRow) begin
      idx.row = TopRow;
      idx.fr  = 9'd256;
    end
  end

endmodule

`default_nettype wire

// ===== test/flux_table_bilinear_interp_test.sv =====
`timescale 1ns / 100ps

module flux_table_bilinear_interp_test;
  import ftbi_pkg::*;

  // Run limits and pacing.
  localparam int CycleLimit     = 200000;
  localparam int DrainCycles    = 20;
  localparam int BeatsPerPhase  = 130;
  localparam int LongHold       = 80;
  localparam int HoldAfterBeats = 30;
  localparam int NumProbes      = 22;

  // Table geometry as instantiated.
  localparam int GridRows = 16;
  localparam int GridCols = 7;

  // Saturation bounds, rigidity in 1/256 GV and potential in MV.
  localparam int unsigned RigLo   = 128;
  localparam int unsigned RigHi   = 3814;
  localparam int unsigned PotLo   = 500;
  localparam int unsigned PotHi   = 1100;
  localparam int unsigned PotSpan = 100;

  // Integrated flux grid, unsigned Q7.8, rows by rigidity and columns by potential.
  localparam int unsigned FluxGrid [GridRows][GridCols] = '{
    '{31293, 22867, 17286, 13433, 10679, 8654, 7128},
    '{17346, 13727, 11074, 9080,  7550,  6355, 5406},
    '{7075,  6057,  5232,  4554,  3993,  3522, 3125},
    '{3692,  3286,  2939,  2641,  2384,  2160, 1964},
    '{2223,  2024,  1849,  1695,  1559,  1437, 1328},
    '{1466,  1356,  1257,  1168,  1088,  1015, 948},
    '{1031,  964,   903,   847,   796,   750,  707},
    '{760,   716,   676,   639,   605,   574,  544},
    '{580,   551,   523,   497,   474,   451,  431},
    '{456,   435,   415,   397,   379,   363,  348},
    '{366,   351,   336,   323,   310,   298,  286},
    '{300,   289,   278,   267,   257,   248,  239},
    '{250,   241,   232,   224,   217,   209,  202},
    '{211,   204,   197,   191,   185,   179,  173},
    '{180,   174,   169,   164,   159,   154,  150},
    '{155,   151,   146,   142,   138,   134,  131}
  };

  // One directed row: inputs, and a typed-in flux where it is obvious.
  typedef struct packed {
    logic [RigWidth-1:0]  rig;
    logic [PotWidth-1:0]  pot;
    logic                 typed;
    logic [FluxWidth-1:0] flux;
  } probe_t;

  // One flux value still owed by the block, with the inputs that caused it.
  typedef struct {
    logic [RigWidth-1:0]  rig;
    logic [PotWidth-1:0]  pot;
    logic [FluxWidth-1:0] flux;
  } flux_due_t;

  // Directed rows: clamps at both ends, exact grid points, the top column,
  // the stretched fraction below 1 GV and alternating bit patterns.
  probe_t probe_table [NumProbes] = '{
    '{12'd0,    11'd0,    1'b1, 15'd31293},
    '{12'd4095, 11'd2047, 1'b0, 15'd0},
    '{12'd128,  11'd500,  1'b1, 15'd31293},
    '{12'd127,  11'd499,  1'b1, 15'd31293},
    '{12'd3814, 11'd1100, 1'b0, 15'd0},
    '{12'd3815, 11'd1101, 1'b0, 15'd0},
    '{12'd256,  11'd500,  1'b1, 15'd17346},
    '{12'd128,  11'd1100, 1'b1, 15'd7128},
    '{12'd0,    11'd2047, 1'b1, 15'd7128},
    '{12'd512,  11'd800,  1'b1, 15'd4554},
    '{12'd3584, 11'd600,  1'b1, 15'd174},
    '{12'd255,  11'd1099, 1'b0, 15'd0},
    '{12'd192,  11'd550,  1'b0, 15'd0},
    '{12'd1024, 11'd1000, 1'b1, 15'd1437},
    '{12'd2047, 11'd1023, 1'b0, 15'd0},
    '{12'd2048, 11'd1024, 1'b0, 15'd0},
    '{12'd3839, 11'd700,  1'b0, 15'd0},
    '{12'd3840, 11'd1050, 1'b0, 15'd0},
    '{12'd2730, 11'd1365, 1'b0, 15'd0},
    '{12'd1365, 11'd682,  1'b0, 15'd0},
    '{12'd300,  11'd1099, 1'b0, 15'd0},
    '{12'd3328, 11'd900,  1'b1, 15'd185}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  ftbi_in_if  item_in ();
  ftbi_out_if flux_out ();

  flux_table_bilinear_interp dut (
    .clk      (clk),
    .rst      (rst),
    .item_in  (item_in),
    .flux_out (flux_out)
  );

  flux_due_t flux_due [$];
  int        flux_errors  = 0;
  int        flux_checked = 0;
  int        src_idle_pct = 0;
  int        sink_idle_pct = 0;
  int        cycle_count = 0;
  bit        hold_req = 1'b0;

  // Clock, 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Saturate both inputs, blend the two rows, then the two columns, and round.
  function automatic logic [FluxWidth-1:0] interp_flux(input logic [RigWidth-1:0] rig,
                                                       input logic [PotWidth-1:0] pot);
    int unsigned     r, p, row, fr, col, fc;
    longint unsigned t0, t1, blend;
    r = rig;
    p = pot;
    if (r < RigLo) r = RigLo;
    if (r > RigHi) r = RigHi;
    if (p < PotLo) p = PotLo;
    if (p > PotHi) p = PotHi;
    // Below 1 GV the half-GV first row is stretched to a full step.
    if (r >= 256) begin
      row = r >> 8;
      fr  = r & 255;
    end else begin
      row = 0;
      fr  = 2 * r - 256;
    end
    if (row > GridRows - 2) begin
      row = GridRows - 2;
      fr  = 256;
    end
    // The top potential reuses the last column pair at fraction one.
    col = (p - PotLo) / PotSpan;
    fc  = (p - PotLo) % PotSpan;
    if (col > GridCols - 2) begin
      col = GridCols - 2;
      fc  = PotSpan;
    end
    t0 = longint'(FluxGrid[row][col]) * (256 - fr)
       + longint'(FluxGrid[row + 1][col]) * fr;
    t1 = longint'(FluxGrid[row][col + 1]) * (256 - fr)
       + longint'(FluxGrid[row + 1][col + 1]) * fr;
    blend = t0 * (PotSpan - fc) + t1 * fc;
    return FluxWidth'((blend + 12800) / 25600);
  endfunction

  // Mostly in-range rigidities, with a share near the clamps and across the field.
  function automatic logic [RigWidth-1:0] pick_rigidity();
    logic [RigWidth-1:0] rig;
    case ($urandom_range(9))
      0, 1:    rig = RigWidth'($urandom_range(4095));
      2:       rig = RigWidth'($urandom_range(300));
      3:       rig = RigWidth'($urandom_range(4095, 3700));
      default: rig = RigWidth'($urandom_range(RigHi, RigLo));
    endcase
    return rig;
  endfunction

  // Potentials follow the same mix around 500..1100 MV.
  function automatic logic [PotWidth-1:0] pick_potential();
    logic [PotWidth-1:0] pot;
    case ($urandom_range(9))
      0, 1:    pot = PotWidth'($urandom_range(2047));
      2:       pot = PotWidth'($urandom_range(520, 450));
      3:       pot = PotWidth'($urandom_range(1150, 1080));
      default: pot = PotWidth'($urandom_range(PotHi, PotLo));
    endcase
    return pot;
  endfunction

  // Offer one beat after a random gap and record what it must produce.
  task automatic offer_beat(input logic [RigWidth-1:0]  rig,
                            input logic [PotWidth-1:0]  pot,
                            input logic                 typed,
                            input logic [FluxWidth-1:0] typed_flux);
    flux_due_t due;
    while ($urandom_range(99) < src_idle_pct) begin
      item_in.valid <= 1'b0;
      @(posedge clk);
    end
    item_in.valid           <= 1'b1;
    item_in.cutoff_rigidity <= rig;
    item_in.solar_potential <= pot;
    @(posedge clk);
    while (!item_in.ready) @(posedge clk);
    due.rig  = rig;
    due.pot  = pot;
    due.flux = typed ? typed_flux : interp_flux(rig, pot);
    flux_due.push_back(due);
  endtask

  // Result side: check each beat against the oldest owed value, then pace ready.
  initial begin
    int        hold_left;
    flux_due_t due;
    hold_left = 0;
    flux_out.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && flux_out.valid && flux_out.ready) begin
        if (flux_due.size() == 0) begin
          $display("%0t: vertical_flux %0d arrived with none outstanding",
                   $time, flux_out.vertical_flux);
          flux_errors++;
        end else begin
          due = flux_due.pop_front();
          flux_checked++;
          if (flux_out.vertical_flux !== due.flux) begin
            $display("%0t: rig %0d pot %0d: vertical_flux expected %0d, actual %0d",
                     $time, due.rig, due.pot, due.flux, flux_out.vertical_flux);
            flux_errors++;
          end
        end
      end
      // A long hold-off lets the pipeline fill and stall the input side.
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        flux_out.ready <= 1'b0;
      end else begin
        flux_out.ready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("flux_table_bilinear_interp: mismatch");
    $finish;
  end

  // Stimulus: reset, the directed rows, then three random phases.
  initial begin
    int random_beats;
    random_beats = 0;
    item_in.valid           = 1'b0;
    item_in.cutoff_rigidity = '0;
    item_in.solar_potential = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    src_idle_pct  = 30;
    sink_idle_pct = 63;
    foreach (probe_table[i]) begin
      offer_beat(probe_table[i].rig, probe_table[i].pot, probe_table[i].typed,
                 probe_table[i].flux);
    end

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 30;
          sink_idle_pct = 63;
        end
        1: begin
          src_idle_pct  = 63;
          sink_idle_pct = 30;
        end
        default: begin
          src_idle_pct  = 0;
          sink_idle_pct = 0;
        end
      endcase
      for (int n = 0; n < BeatsPerPhase; n++) begin
        if (phase == 2 && n == HoldAfterBeats) hold_req = 1'b1;
        offer_beat(pick_rigidity(), pick_potential(), 1'b0, '0);
        random_beats++;
      end
    end
    item_in.valid <= 1'b0;

    // Drain, then allow for the pipeline depth.
    while (flux_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Offered %0d directed and %0d random beats with idling on both sides,",
             NumProbes, random_beats);
    $display("including a %0d-cycle output hold-off; %0d flux results checked.",
             LongHold, flux_checked);
    if (flux_errors == 0 && flux_due.size() == 0) begin
      $display("flux_table_bilinear_interp: match");
    end else begin
      $display("flux_table_bilinear_interp: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ftbi_pkg.sv
rtl/ftbi_in_if.sv
rtl/ftbi_out_if.sv
rtl/ftbi_front.sv
rtl/flux_table_bilinear_interp.sv
test/flux_table_bilinear_interp_test.sv
